FILE: rtl/core/gqlc_pkg.sv
// ----------------------------------------------------------------------------
// gqlc_pkg
// Types, codes and defaults shared by the lock coordinator modules.
// ----------------------------------------------------------------------------
package gqlc_pkg;

  localparam int unsigned MaxConnectionsDefault = 128;
  localparam int unsigned QueueDepthDefault     = 64;
  localparam int unsigned TallyEntriesDefault   = 128;
  localparam int unsigned CountWidthDefault     = 32;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned SlotW  = 7;
  localparam int unsigned ProcW  = 22;
  localparam int unsigned DropW  = 7;
  localparam int unsigned CountW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_CONNECT    = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_REQUEST    = 3'd2,
    CMD_RELEASE    = 3'd3
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [SlotW-1:0] connection;
    logic [ProcW-1:0] process_id;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [SlotW-1:0]  grant_connection;
    logic [ProcW-1:0]  grant_process;
    logic [DropW-1:0]  dropped_entries;
    logic              queue_full;
    logic [CountW-1:0] serve_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_BUMP,
    ST_TALLY_WR,
    ST_DISPATCH,
    ST_POP_WAIT,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic event_apply;
    logic scan_start;
    logic scan_step;
    logic bump_write;
    logic pop_apply;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic is_release;
    logic scan_last;
    logic scan_hit;
    logic can_pop;
  } sts_t;

endpackage

FILE: rtl/core/grant_queue_lock_coordinator.sv
// ----------------------------------------------------------------------------
// grant_queue_lock_coordinator
// Centralized lock coordinator with request FIFO and serve tally.
// ----------------------------------------------------------------------------
// One item at a time: an item is accepted only in the idle state. A release walks
// the tally table one entry at a time, each entry through a wait state for the
// registered memory read, then writes the bumped count. Each FIFO entry the
// dispatcher pops goes through a wait state and a pop state. The result sits in an
// output register, so the next item enters while it waits.
module grant_queue_lock_coordinator import gqlc_pkg::*; #(
  parameter int unsigned MAX_CONNECTIONS = MaxConnectionsDefault,
  parameter int unsigned QUEUE_DEPTH     = QueueDepthDefault,
  parameter int unsigned TALLY_ENTRIES   = TallyEntriesDefault,
  parameter int unsigned COUNT_WIDTH     = CountWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_t ctl;
  sts_t sts;
  logic load;

  gqlc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .ctl, .load
  );

  gqlc_datapath #(
    .MAX_CONNECTIONS(MAX_CONNECTIONS), .QUEUE_DEPTH(QUEUE_DEPTH),
    .TALLY_ENTRIES(TALLY_ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk, .rst, .load, .item(in_data), .ctl, .sts, .result(out_data)
  );

endmodule

FILE: rtl/core/gqlc_datapath.sv
// ----------------------------------------------------------------------------
// gqlc_datapath
// FIFO, connection table, holder, serve tally and result register.
// ----------------------------------------------------------------------------
module gqlc_datapath import gqlc_pkg::*; #(
  parameter int unsigned MAX_CONNECTIONS = MaxConnectionsDefault,
  parameter int unsigned QUEUE_DEPTH     = QueueDepthDefault,
  parameter int unsigned TALLY_ENTRIES   = TallyEntriesDefault,
  parameter int unsigned COUNT_WIDTH     = CountWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  in_item_t  item,
  input  ctl_t      ctl,
  output sts_t      sts,
  output out_item_t result
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TAW = (TALLY_ENTRIES > 1) ? $clog2(TALLY_ENTRIES) : 1;
  localparam int unsigned TCW = $clog2(TALLY_ENTRIES + 1);
  localparam int unsigned CAW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int unsigned EW  = 1 + SlotW + ProcW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  in_item_t              cur;
  logic [EW-1:0]         fifo_mem [QUEUE_DEPTH];
  logic [EW-1:0]         head_q;
  logic [QAW-1:0]        fifo_head;
  logic [QAW-1:0]        fifo_tail;
  logic [LW-1:0]         fifo_level;
  logic [MAX_CONNECTIONS-1:0] connection_live;
  logic                  holder_valid;
  logic [SlotW-1:0]      holder_slot;

  logic [TALLY_ENTRIES-1:0] tally_valid;
  logic [ProcW+COUNT_WIDTH-1:0] tally_mem [TALLY_ENTRIES];
  logic [ProcW+COUNT_WIDTH-1:0] tally_q;
  logic [TCW-1:0]        scan_idx;
  logic [TAW-1:0]        rd_idx;
  logic [TAW-1:0]        hit_idx;
  logic [COUNT_WIDTH-1:0] hit_cnt;
  logic                  hit;
  logic                  free_found;
  logic [TAW-1:0]        free_idx;
  logic [COUNT_WIDTH-1:0] bump_val;

  logic                  granted;
  logic [SlotW-1:0]      gslot;
  logic [ProcW-1:0]      gproc;
  logic [DropW-1:0]      dropped;
  logic                  full;
  logic [CountW-1:0]     count;

  logic                  cur_in_range;
  logic [CAW-1:0]        cur_ci;
  logic                  head_unknown;
  logic [SlotW-1:0]      head_slot;
  logic [ProcW-1:0]      head_proc;
  logic                  head_in_range;
  logic [CAW-1:0]        head_ci;
  logic                  is_enq;

  assign cur_in_range  = 32'(cur.connection) < MAX_CONNECTIONS;
  assign cur_ci        = CAW'(cur.connection);
  assign head_unknown  = head_q[EW-1];
  assign head_slot     = head_q[EW-2 -: SlotW];
  assign head_proc     = head_q[ProcW-1:0];
  assign head_in_range = 32'(head_slot) < MAX_CONNECTIONS;
  assign head_ci       = CAW'(head_slot);
  assign is_enq        = cur.command != CMD_CONNECT && cur.command != CMD_DISCONNECT &&
                         cur.command != CMD_RELEASE;
  assign rd_idx        = TAW'(scan_idx);

  assign sts.is_release = cur.command == CMD_RELEASE;
  assign sts.scan_last  = 32'(scan_idx) >= TALLY_ENTRIES - 1;
  assign sts.scan_hit   = hit;
  assign sts.can_pop    = !holder_valid && fifo_level != '0;

  always_comb begin
    if (!hit) begin
      bump_val = COUNT_WIDTH'(1);
    end else if (hit_cnt != CountMax) begin
      bump_val = hit_cnt + COUNT_WIDTH'(1);
    end else begin
      bump_val = hit_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item;
    end
    head_q <= fifo_mem[fifo_head];
    tally_q <= tally_mem[rd_idx];
    if (ctl.event_apply && is_enq && 32'(fifo_level) < QUEUE_DEPTH) begin
      fifo_mem[fifo_tail] <= {cur.command != CMD_REQUEST, cur.connection, cur.process_id};
    end
    if (ctl.bump_write && (hit || free_found)) begin
      tally_mem[hit ? hit_idx : free_idx] <= {cur.process_id, bump_val};
    end
    if (ctl.out_load) begin
      result.granted          <= granted;
      result.grant_connection <= gslot;
      result.grant_process    <= gproc;
      result.dropped_entries  <= dropped;
      result.queue_full       <= full;
      result.serve_count      <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head       <= '0;
      fifo_tail       <= '0;
      fifo_level      <= '0;
      connection_live <= '0;
      holder_valid    <= 1'b0;
      holder_slot     <= '0;
      tally_valid     <= '0;
      scan_idx        <= '0;
      hit             <= 1'b0;
      hit_idx         <= '0;
      hit_cnt         <= '0;
      free_found      <= 1'b0;
      free_idx        <= '0;
      granted         <= 1'b0;
      gslot           <= '0;
      gproc           <= '0;
      dropped         <= '0;
      full            <= 1'b0;
      count           <= '0;
    end else begin
      if (load) begin
        granted <= 1'b0;
        gslot   <= '0;
        gproc   <= '0;
        dropped <= '0;
        full    <= 1'b0;
        count   <= '0;
      end
      if (ctl.event_apply) begin
        unique case (cur.command)
          CMD_CONNECT: begin
            if (cur_in_range) connection_live[cur_ci] <= 1'b1;
          end
          CMD_DISCONNECT: begin
            if (cur_in_range) begin
              connection_live[cur_ci] <= 1'b0;
              if (holder_valid && holder_slot == cur.connection) holder_valid <= 1'b0;
            end
          end
          CMD_RELEASE: begin
            if (holder_valid && holder_slot == cur.connection) holder_valid <= 1'b0;
          end
          default: begin
            if (32'(fifo_level) >= QUEUE_DEPTH) begin
              full <= 1'b1;
            end else begin
              fifo_tail  <= (32'(fifo_tail) == QUEUE_DEPTH - 1) ? '0 : fifo_tail + QAW'(1);
              fifo_level <= fifo_level + LW'(1);
            end
          end
        endcase
      end
      if (ctl.scan_start) begin
        scan_idx   <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (ctl.scan_step) begin
        // tally_q holds entry rd_idx, read last cycle
        if (tally_valid[rd_idx] && tally_q[ProcW+COUNT_WIDTH-1:COUNT_WIDTH] == cur.process_id) begin
          hit     <= 1'b1;
          hit_idx <= rd_idx;
          hit_cnt <= tally_q[COUNT_WIDTH-1:0];
        end else if (!tally_valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (!sts.scan_last) scan_idx <= scan_idx + TCW'(1);
      end
      if (ctl.bump_write) begin
        if (hit) begin
          count <= CountW'(bump_val);
        end else if (free_found) begin
          tally_valid[free_idx] <= 1'b1;
          count <= CountW'(1);
        end
      end
      if (ctl.pop_apply) begin
        fifo_head  <= (32'(fifo_head) == QUEUE_DEPTH - 1) ? '0 : fifo_head + QAW'(1);
        fifo_level <= fifo_level - LW'(1);
        if (head_unknown) begin
          if (head_in_range) connection_live[head_ci] <= 1'b0;
          dropped <= dropped + DropW'(1);
        end else if (head_in_range && connection_live[head_ci]) begin
          holder_valid <= 1'b1;
          holder_slot  <= head_slot;
          granted      <= 1'b1;
          gslot        <= head_slot;
          gproc        <= head_proc;
        end else begin
          dropped <= dropped + DropW'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/core/gqlc_ctrl.sv
// ----------------------------------------------------------------------------
// gqlc_ctrl
// Sequencer: event, tally search, dispatch loop and result handoff.
// ----------------------------------------------------------------------------
module gqlc_ctrl import gqlc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output ctl_t ctl,
  output logic load
);

  state_e state, state_next;
  logic   out_pending, out_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_pending <= 1'b0;
    end else begin
      state       <= state_next;
      out_pending <= out_pending_next;
    end
  end

  assign out_valid = out_pending;

  always_comb begin
    state_next       = state;
    ctl              = '0;
    in_stall         = 1'b1;
    load             = 1'b0;
    out_pending_next = out_pending && out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          load       = 1'b1;
          state_next = ST_EVENT;
        end
      end
      ST_EVENT: begin
        ctl.event_apply = 1'b1;
        if (sts.is_release) begin
          ctl.scan_start = 1'b1;
          state_next     = ST_SCAN_WAIT;
        end else begin
          state_next = ST_DISPATCH;
        end
      end
      ST_SCAN_WAIT: state_next = ST_SCAN;
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        state_next = sts.scan_last ? ST_BUMP : ST_SCAN_WAIT;
      end
      ST_BUMP: begin
        state_next = ST_TALLY_WR;
      end
      ST_TALLY_WR: begin
        ctl.bump_write = 1'b1;
        state_next     = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_next = sts.can_pop ? ST_POP_WAIT : ST_DONE;
      end
      ST_POP_WAIT: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        ctl.pop_apply = 1'b1;
        state_next    = ST_DISPATCH;
      end
      ST_DONE: begin
        if (!out_pending) begin
          ctl.out_load     = 1'b1;
          out_pending_next = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
